// ===== sv/sha512c_pkg.sv =====
package sha512c_pkg;

  // Fixed widths of the data path
  localparam int unsigned WordW     = 64;
  localparam int unsigned Rounds    = 80;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned HashWords = 8;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Mode register codes
  localparam logic ModeSha512 = 1'b0;
  localparam logic ModeSha384 = 1'b1;

  // Index of the final digest word per mode
  localparam logic [2:0] LastIdxSha512 = 3'd7;
  localparam logic [2:0] LastIdxSha384 = 3'd5;

  localparam logic [3:0] LastWordIdx = 4'd15;
  localparam logic [6:0] LastRound   = 7'd79;

  // One input beat
  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             start_message;
    logic             last_block;
  } msg_in_t;

  // One output beat
  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic             digest_last;
  } digest_out_t;

  // Classified word, carried from front to back through the queue
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             start;
    logic             block_end;
    logic             emit;
  } cmd_t;

  // Back-end status seen at the top level
  typedef struct packed {
    logic emitting;
    logic folding;
    logic round_last;
  } back_status_t;

  localparam logic [WordW-1:0] Iv512 [HashWords] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
    64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam logic [WordW-1:0] Iv384 [HashWords] = '{
    64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
    64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
    64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
  };

  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
    64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
    64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
    64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
    64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
    64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
    64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
    64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
    64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
    64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
    64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
    64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
    64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
    64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
    64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
    64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
    64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
    64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
    64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
    64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
    64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  // Round constant lookup; indexes past the last round read as zero
  function automatic logic [WordW-1:0] round_k(input logic [6:0] idx);
    logic [WordW-1:0] k;
    k = '0;
    if (idx <= LastRound) begin
      k = RoundK[idx];
    end
    return k;
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
  endfunction

endpackage

// ===== sv/sha512c_front.sv =====
module sha512c_front
  import sha512c_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  msg_in_t in_data_i,
  output logic    push_o,
  output cmd_t    cmd_o,
  input  logic    full_i
);

  logic [3:0] word_cnt_q, word_cnt_d;
  logic       final_q, final_d;
  logic [3:0] cnt_eff;
  logic       fin_eff;
  logic       block_end;

  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;

  // Classify the beat: a start drops any partial block and clears the last flag
  always_comb begin
    cnt_eff   = in_data_i.start_message ? 4'd0 : word_cnt_q;
    fin_eff   = (in_data_i.start_message ? 1'b0 : final_q) | in_data_i.last_block;
    block_end = (cnt_eff == LastWordIdx);

    cmd_o.word      = in_data_i.message_word;
    cmd_o.start     = in_data_i.start_message;
    cmd_o.block_end = block_end;
    cmd_o.emit      = block_end & fin_eff;

    word_cnt_d = word_cnt_q;
    final_d    = final_q;
    if (push_o) begin
      word_cnt_d = block_end ? 4'd0 : cnt_eff + 4'd1;
      final_d    = block_end ? 1'b0 : fin_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt_q <= '0;
      final_q    <= 1'b0;
    end else begin
      word_cnt_q <= word_cnt_d;
      final_q    <= final_d;
    end
  end

endmodule

// ===== sv/sha512c_fifo.sv =====
module sha512c_fifo
  import sha512c_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/sha512c_back.sv =====
module sha512c_back
  import sha512c_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         digest_mode_i,
  input  logic         cmd_valid_i,
  input  cmd_t         cmd_i,
  output logic         cmd_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output digest_out_t  out_data_o,
  output back_status_t status_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPrep  = 5'b00010,
    StRound = 5'b00100,
    StFold  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [WordW-1:0]  win_q [BlockWords];
  logic [WordW-1:0]  win_d [BlockWords];
  logic [WordW-1:0]  v_q   [HashWords];
  logic [WordW-1:0]  v_d   [HashWords];
  logic [WordW-1:0]  cv_q  [HashWords];
  logic [WordW-1:0]  cv_d  [HashWords];
  logic [WordW-1:0]  pre_q, pre_d;
  logic [6:0]        rnd_q, rnd_d;
  logic [2:0]        idx_q, idx_d;
  logic              fin_q, fin_d;
  logic              out_valid_q, out_valid_d;
  digest_out_t       out_q, out_d;

  logic [WordW-1:0]  t1, t2, ch, maj, w_new;
  logic [2:0]        last_idx;
  logic              out_free;

  assign cmd_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign last_idx    = (digest_mode_i == ModeSha384) ? LastIdxSha384 : LastIdxSha512;

  assign status_o.emitting   = (state_q == StEmit);
  assign status_o.folding    = (state_q == StFold);
  assign status_o.round_last = (state_q == StRound) && (rnd_q == LastRound);

  // Round function; pre_q already holds h + K[t] + W[t]
  always_comb begin
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = pre_q + big_sigma1(v_q[4]) + ch;
    t2    = big_sigma0(v_q[0]) + maj;
    w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    v_d         = v_q;
    cv_d        = cv_q;
    pre_d       = pre_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;

    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          // shift the word into the block window
          for (int j = 0; j < BlockWords - 1; j++) begin
            win_d[j] = win_q[j+1];
          end
          win_d[BlockWords-1] = cmd_i.word;
          if (cmd_i.start) begin
            for (int i = 0; i < HashWords; i++) begin
              cv_d[i] = (digest_mode_i == ModeSha384) ? Iv384[i] : Iv512[i];
            end
          end
          if (cmd_i.block_end) begin
            fin_d   = cmd_i.emit;
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        v_d     = cv_q;
        pre_d   = cv_q[7] + round_k(7'd0) + win_q[0];
        rnd_d   = '0;
        state_d = StRound;
      end
      StRound: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        // expand the schedule in place
        for (int j = 0; j < BlockWords - 1; j++) begin
          win_d[j] = win_q[j+1];
        end
        win_d[BlockWords-1] = w_new;
        pre_d = v_q[6] + round_k(rnd_q + 7'd1) + win_q[1];
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LastRound) begin
          state_d = StFold;
        end
      end
      StFold: begin
        for (int i = 0; i < HashWords; i++) begin
          cv_d[i] = cv_q[i] + v_q[i];
        end
        idx_d   = '0;
        state_d = fin_q ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.digest_word = cv_q[idx_q];
          out_d.digest_last = (idx_q == last_idx);
          idx_d             = idx_q + 3'd1;
          if (idx_q == last_idx) begin
            fin_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_q       <= '0;
      idx_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HashWords; i++) begin
        cv_q[i] <= Iv512[i];
      end
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      cv_q        <= cv_d;
    end
  end

  // Data path registers
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
    pre_q <= pre_d;
    out_q <= out_d;
  end

endmodule

// ===== sv/sha512_block_compressor.sv =====
// SHA-512 / SHA-384 compression engine for host-padded messages.
// Input channel (in_valid_i/in_ready_o/in_data_i): one 64-bit big-endian
// message word per beat, sixteen per block, with start_message on the first
// word of a message and last_block on any word of the final block.
// Output channel (out_valid_o/out_ready_i/out_data_o): digest words, most
// significant first, eight for SHA-512 or six for SHA-384, digest_last on
// the final one. Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes
// digest_mode (0 = SHA-512, 1 = SHA-384); write it only while idle.
// Words enter a small command queue at up to one per cycle while it is not
// full. The back end takes one word per cycle while idle, then runs a full
// block: it loads the working words, runs 80 rounds at one per cycle and
// folds into the chaining value. A final block then adds the digest output.
// The back end takes no word while it runs a block.
// Reset loads the SHA-512 initial values and clears counters and the queue.
// When the receiver stalls, the output register holds the beat, the back end
// waits, the queue fills and then in_ready_o drops.
module sha512_block_compressor
  import sha512c_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  msg_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output digest_out_t out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic         digest_mode_q;
  logic         push, full, pop, cmd_valid, cmd_ready;
  cmd_t         cmd_in, cmd_out;
  back_status_t back_status;

  // Mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_mode_q <= ModeSha512;
    end else if (cfg_valid_i && cfg_ready_o) begin
      digest_mode_q <= cfg_data_i;
    end
  end

  sha512c_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  sha512c_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  assign pop = cmd_valid & cmd_ready;

  sha512c_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .digest_mode_i (digest_mode_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_ready_o   (cmd_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .status_o      (back_status)
  );

  // No beat is pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !push)
    else $error("command queue overflow");

  // The queue is not drained while digest words go out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.emitting |-> !pop)
    else $error("command popped during digest output");

  // The last round is followed by the fold into the chaining value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.round_last |=> back_status.folding)
    else $error("fold did not follow the last round");

endmodule
